// ----- hw/rtl/asmf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asmf_pkg
// Shared types, constants and helpers for the analog spike median filter.
// ----------------------------------------------------------------------------
package asmf_pkg;

   localparam int CHANNELS  = 16;
   localparam int CH_W      = 4;
   localparam int CH_CMP_W  = 7;
   localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam int RAW_W     = 12;
   localparam int VOLT_W    = 20;
   localparam int VAL_W     = 32;
   localparam int THR_W     = 31;
   localparam int PROD_W    = 64;
   localparam int CSR_IDX_W = 3;

   // divider: |num| << 16 over |gain|, one quotient bit per cycle
   localparam int DIV_W     = 49;
   localparam int DIV_CNT_W = 6;

   localparam logic [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
   localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;

   localparam logic [VOLT_W-1:0] VREF_RESET    = 20'd327680;
   localparam logic [VOLT_W-1:0] MIN_RESET     = 20'd0;
   localparam logic [VOLT_W-1:0] MAX_RESET     = 20'd786432;
   localparam logic [VAL_W-1:0]  GAIN_RESET    = 32'd65536;
   localparam logic [VAL_W-1:0]  OFFSET_RESET  = 32'd0;
   localparam logic [THR_W-1:0]  TEMP_RESET    = 31'd65536;
   localparam logic [THR_W-1:0]  HUMI_RESET    = 31'd65536;
   localparam logic [VOLT_W-1:0] DC_RESET      = 20'd65536;

   // x / 240 == (x >> 4) / 15; reciprocal of 15 scaled by 2^20, exact for 16-bit operands
   localparam logic [16:0] RECIP15       = 17'd69906;
   localparam int          RECIP15_SHIFT = 20;

   typedef enum logic [CSR_IDX_W-1:0] {
      CFG_VREF   = 3'd0,
      CFG_MIN    = 3'd1,
      CFG_MAX    = 3'd2,
      CFG_GAIN   = 3'd3,
      CFG_OFFSET = 3'd4,
      CFG_TEMP   = 3'd5,
      CFG_HUMI   = 3'd6,
      CFG_DC     = 3'd7
   } cfg_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_V1_MUL,
      ST_V1_CLAMP,
      ST_DIV,
      ST_BACK,
      ST_DIFF,
      ST_DIFF_MUL,
      ST_DIFF_ENG,
      ST_V2_MUL,
      ST_V2_CLAMP,
      ST_RES_MUL,
      ST_RES_ENG,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   function automatic logic [VOLT_W-1:0] clamp_volts(
      input logic [VOLT_W-1:0] v,
      input logic [VOLT_W-1:0] lo,
      input logic [VOLT_W-1:0] hi
   );
      logic [VOLT_W-1:0] r;
      // upper clamp is tested first; with crossed limits only values above hi get hi, the rest get lo
      if (v > hi) begin
         r = hi;
      end else if (v < lo) begin
         r = lo;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [VOLT_W-1:0] div240(input logic [VOLT_W-1:0] x);
      logic [15:0] y;
      logic [32:0] p;
      y = x[VOLT_W-1:4];
      p = {17'd0, y} * {16'd0, RECIP15};
      return VOLT_W'(p >> RECIP15_SHIFT);
   endfunction

endpackage

// ----- hw/rtl/asmf_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asmf_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module asmf_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [asmf_pkg::DIV_W-1:0]       dividend,
   input  logic [asmf_pkg::VAL_W-1:0]       divisor,
   output logic [asmf_pkg::DIV_W-1:0]       quotient,
   output asmf_pkg::div_status_type         status
);

   logic [asmf_pkg::VAL_W-1:0]     rem_ff, rem_in;
   logic [asmf_pkg::DIV_W-1:0]     quo_ff, quo_in;
   logic [asmf_pkg::VAL_W-1:0]     dvs_ff;
   logic [asmf_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [asmf_pkg::VAL_W:0]       trial;
   logic                           fits;

   // quo_ff shifts dividend bits out at the top and quotient bits in at the bottom
   assign trial = {rem_ff, quo_ff[asmf_pkg::DIV_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = asmf_pkg::DIV_CNT_W'(asmf_pkg::DIV_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? asmf_pkg::VAL_W'(trial - {1'b0, dvs_ff})
                       : asmf_pkg::VAL_W'(trial);
         quo_in = {quo_ff[asmf_pkg::DIV_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         dvs_ff <= divisor;
      end
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ----- hw/rtl/asmf_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asmf_mul
// Shared registered 32x32 signed multiplier with Q16.16 scale-and-offset.
// ----------------------------------------------------------------------------
module asmf_mul (
   input  logic                               clock,
   input  logic signed [asmf_pkg::VAL_W-1:0]  op_a,
   input  logic signed [asmf_pkg::VAL_W-1:0]  op_b,
   input  logic signed [asmf_pkg::VAL_W-1:0]  offset,
   output logic signed [asmf_pkg::PROD_W-1:0] product,
   output logic        [asmf_pkg::VAL_W-1:0]  eng_value
);

   logic signed [asmf_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [asmf_pkg::PROD_W-1:0] biased;
   logic signed [47:0]                 scaled;
   logic signed [48:0]                 sum;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // divide by 65536 truncating toward zero, add offset, saturate
   always_comb begin
      biased = prod_ff + (prod_ff[asmf_pkg::PROD_W-1] ? 64'sd65535 : 64'sd0);
      scaled = biased[asmf_pkg::PROD_W-1:16];
      sum    = {scaled[47], scaled} + {{17{offset[asmf_pkg::VAL_W-1]}}, offset};
      if (sum > 49'sh0_7FFF_FFFF) begin
         eng_value = asmf_pkg::VAL_MAX;
      end else if (sum < -49'sh0_8000_0000) begin
         eng_value = asmf_pkg::VAL_MIN;
      end else begin
         eng_value = sum[asmf_pkg::VAL_W-1:0];
      end
   end

   assign product = prod_ff;

endmodule

// ----- hw/rtl/analog_spike_median_filter_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// analog_spike_median_filter_core
// Per-channel spike filter: average or median of three, Q16.16 output.
// ----------------------------------------------------------------------------
// One request is handled at a time by a sequencer around a shared registered
// multiplier and a bit-serial divider. The back-conversion division (stored
// value minus offset over gain, 49 quotient bits at one per cycle) is the
// longest step of a request and is skipped when gain_k is zero. The next
// request is accepted at the earliest in the cycle after the result is
// loaded, so no new request is taken while one is in flight. A finished
// result waits in the output register while the next request is accepted.
// The channel store is cleared by reset. Configuration writes are taken at
// any time but should be made only while the block is idle.
module analog_spike_median_filter_core (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [asmf_pkg::CH_W-1:0]           req_channel,
   input  logic [asmf_pkg::RAW_W-1:0]          req_first_raw,
   input  logic [asmf_pkg::RAW_W-1:0]          req_second_raw,
   input  logic                                req_channel_is_current,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [asmf_pkg::CH_W-1:0]           rsp_out_channel,
   output logic signed [asmf_pkg::VAL_W-1:0]   rsp_filtered_value,
   output logic                                rsp_resampled,
   output logic                                rsp_stored,
   // configuration
   input  logic                                csr_write,
   input  logic [asmf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [asmf_pkg::VAL_W-1:0]          csr_data
);

   localparam int VW = asmf_pkg::VAL_W;

   // configuration registers
   logic [asmf_pkg::VOLT_W-1:0] vref_ff, min_ff, max_ff, dc_thr_ff;
   logic [VW-1:0]               gain_ff, offset_ff;
   logic [asmf_pkg::THR_W-1:0]  temp_thr_ff, humi_thr_ff;

   asmf_pkg::state_type state_ff, state_in;

   logic [asmf_pkg::CH_W-1:0]   ch_ff;
   logic [asmf_pkg::RAW_W-1:0]  raw1_ff, raw2_ff;
   logic                        cur_ff;
   logic signed [VW:0]          num_ff;
   logic [asmf_pkg::VOLT_W-1:0] v1_ff, v2_ff;
   logic signed [VW-1:0]        back_ff, back_in;
   logic [VW:0]                 diff_ff;
   logic                        spike_ff;
   logic [VW-1:0]               result_ff;
   logic                        keep_ff;
   logic [VW-1:0]               store_ff [asmf_pkg::CHANNELS];

   logic                        rsp_valid_ff;
   logic [asmf_pkg::CH_W-1:0]   rsp_ch_ff;
   logic [VW-1:0]               rsp_value_ff;
   logic                        rsp_resampled_ff, rsp_stored_ff;

   logic                        accept, in_range, gain_zero, ch_low, rsp_load, div_start;
   logic [asmf_pkg::CH_CMP_W-1:0] ch_wide, req_ch_wide;
   logic [asmf_pkg::CH_IDX_W-1:0] idx;

   logic signed [VW-1:0]        mul_a, mul_b;
   logic signed [asmf_pkg::PROD_W-1:0] product;
   logic [VW-1:0]               eng_value;

   logic [asmf_pkg::DIV_W-1:0]  div_dividend, quotient;
   logic [VW-1:0]               gain_mag;
   logic [VW:0]                 num_mag;
   logic                        quot_neg;
   asmf_pkg::div_status_type    div_status;

   logic signed [VW+1:0]        dv;
   logic [VW:0]                 diff_in;
   logic [VW-1:0]               diff_sat;
   logic [asmf_pkg::VOLT_W-1:0] dc_sel;
   logic                        spike_in;
   logic signed [VW-1:0]        v1_s, v2_s, hi, lo, mid, avg;
   logic signed [VW:0]          sum2, sum2_adj;

   assign gain_zero   = gain_ff == '0;
   assign req_ch_wide = {{(asmf_pkg::CH_CMP_W - asmf_pkg::CH_W){1'b0}}, req_channel};
   assign ch_wide     = {{(asmf_pkg::CH_CMP_W - asmf_pkg::CH_W){1'b0}}, ch_ff};
   assign idx         = ch_wide[asmf_pkg::CH_IDX_W-1:0];
   assign in_range    = req_ch_wide < asmf_pkg::CH_CMP_W'(asmf_pkg::CHANNELS);
   assign accept      = req_valid && !req_stall;
   assign ch_low      = ch_ff[asmf_pkg::CH_W-1:1] == '0;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         vref_ff     <= asmf_pkg::VREF_RESET;
         min_ff      <= asmf_pkg::MIN_RESET;
         max_ff      <= asmf_pkg::MAX_RESET;
         gain_ff     <= asmf_pkg::GAIN_RESET;
         offset_ff   <= asmf_pkg::OFFSET_RESET;
         temp_thr_ff <= asmf_pkg::TEMP_RESET;
         humi_thr_ff <= asmf_pkg::HUMI_RESET;
         dc_thr_ff   <= asmf_pkg::DC_RESET;
      end else if (csr_write) begin
         unique case (asmf_pkg::cfg_index_type'(csr_index))
            asmf_pkg::CFG_VREF:   vref_ff     <= csr_data[asmf_pkg::VOLT_W-1:0];
            asmf_pkg::CFG_MIN:    min_ff      <= csr_data[asmf_pkg::VOLT_W-1:0];
            asmf_pkg::CFG_MAX:    max_ff      <= csr_data[asmf_pkg::VOLT_W-1:0];
            asmf_pkg::CFG_GAIN:   gain_ff     <= csr_data;
            asmf_pkg::CFG_OFFSET: offset_ff   <= csr_data;
            asmf_pkg::CFG_TEMP:   temp_thr_ff <= csr_data[asmf_pkg::THR_W-1:0];
            asmf_pkg::CFG_HUMI:   humi_thr_ff <= csr_data[asmf_pkg::THR_W-1:0];
            asmf_pkg::CFG_DC:     dc_thr_ff   <= csr_data[asmf_pkg::VOLT_W-1:0];
         endcase
      end
   end

   // ---------------- shared units ----------------
   asmf_mul u_mul (
      .clock     (clock),
      .op_a      (mul_a),
      .op_b      (mul_b),
      .offset    (offset_ff),
      .product   (product),
      .eng_value (eng_value)
   );

   assign num_mag      = num_ff[VW] ? VW'(0) - num_ff : num_ff;
   assign gain_mag     = gain_ff[VW-1] ? VW'(0) - gain_ff : gain_ff;
   assign quot_neg     = num_ff[VW] ^ gain_ff[VW-1];
   assign div_dividend = {num_mag, 16'd0};

   asmf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (gain_mag),
      .quotient (quotient),
      .status   (div_status)
   );

   // ---------------- datapath helpers ----------------
   always_comb begin
      if (gain_zero) begin
         back_in = num_ff[VW] ? asmf_pkg::VAL_MIN : asmf_pkg::VAL_MAX;
      end else if (!quot_neg) begin
         back_in = (quotient > asmf_pkg::DIV_W'(asmf_pkg::VAL_MAX))
                   ? asmf_pkg::VAL_MAX : quotient[VW-1:0];
      end else begin
         back_in = (quotient > asmf_pkg::DIV_W'(asmf_pkg::VAL_MIN))
                   ? asmf_pkg::VAL_MIN : VW'(0) - quotient[VW-1:0];
      end
   end

   assign dv       = $signed({{(VW + 2 - asmf_pkg::VOLT_W){1'b0}}, v1_ff})
                     - $signed({{2{back_ff[VW-1]}}, back_ff});
   assign diff_in  = dv[VW+1] ? VW'(0) - VW'(0) + (VW+1)'(-dv) : (VW+1)'(dv);
   assign diff_sat = (diff_ff > (VW+1)'(asmf_pkg::VAL_MAX)) ? asmf_pkg::VAL_MAX
                                                            : diff_ff[VW-1:0];
   assign dc_sel   = cur_ff ? asmf_pkg::div240(dc_thr_ff) : dc_thr_ff;

   always_comb begin
      if (ch_low) begin
         spike_in = $signed(eng_value) > $signed({1'b0, ch_ff[0] ? humi_thr_ff : temp_thr_ff});
      end else begin
         spike_in = diff_ff > {{(VW + 1 - asmf_pkg::VOLT_W){1'b0}}, dc_sel};
      end
   end

   assign v1_s = $signed({{(VW - asmf_pkg::VOLT_W){1'b0}}, v1_ff});
   assign v2_s = $signed({{(VW - asmf_pkg::VOLT_W){1'b0}}, v2_ff});
   assign hi   = (v1_s > back_ff) ? v1_s : back_ff;
   assign lo   = (v1_s > back_ff) ? back_ff : v1_s;

   always_comb begin
      priority if (hi <= v2_s) begin
         mid = hi;
      end else if (v2_s <= lo) begin
         mid = lo;
      end else begin
         mid = v2_s;
      end
   end

   // average, halved toward zero
   assign sum2     = $signed({back_ff[VW-1], back_ff}) + $signed({1'b0, v1_s});
   assign sum2_adj = sum2 + (sum2[VW] ? (VW+1)'(1) : (VW+1)'(0));
   assign avg      = VW'(sum2_adj >>> 1);

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         asmf_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = in_range ? asmf_pkg::ST_V1_MUL : asmf_pkg::ST_OUT;
            end
         end
         asmf_pkg::ST_V1_MUL:   state_in = asmf_pkg::ST_V1_CLAMP;
         asmf_pkg::ST_V1_CLAMP: state_in = gain_zero ? asmf_pkg::ST_BACK : asmf_pkg::ST_DIV;
         asmf_pkg::ST_DIV: begin
            if (div_status.done) begin
               state_in = asmf_pkg::ST_BACK;
            end
         end
         asmf_pkg::ST_BACK:     state_in = asmf_pkg::ST_DIFF;
         asmf_pkg::ST_DIFF:     state_in = asmf_pkg::ST_DIFF_MUL;
         asmf_pkg::ST_DIFF_MUL: state_in = asmf_pkg::ST_DIFF_ENG;
         asmf_pkg::ST_DIFF_ENG: state_in = asmf_pkg::ST_V2_MUL;
         asmf_pkg::ST_V2_MUL:   state_in = asmf_pkg::ST_V2_CLAMP;
         asmf_pkg::ST_V2_CLAMP: state_in = asmf_pkg::ST_RES_MUL;
         asmf_pkg::ST_RES_MUL:  state_in = asmf_pkg::ST_RES_ENG;
         asmf_pkg::ST_RES_ENG:  state_in = asmf_pkg::ST_OUT;
         asmf_pkg::ST_OUT: begin
            if (rsp_load) begin
               state_in = asmf_pkg::ST_IDLE;
            end
         end
         default:               state_in = asmf_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = state_ff != asmf_pkg::ST_IDLE;
      div_start = (state_ff == asmf_pkg::ST_V1_CLAMP) && !gain_zero;
      rsp_load  = (state_ff == asmf_pkg::ST_OUT) && (!rsp_valid_ff || !rsp_stall);
      mul_a     = '0;
      mul_b     = '0;
      unique case (state_ff)
         asmf_pkg::ST_V1_MUL: begin
            mul_a = $signed({{(VW - asmf_pkg::RAW_W){1'b0}}, raw1_ff});
            mul_b = $signed({{(VW - asmf_pkg::VOLT_W){1'b0}}, vref_ff});
         end
         asmf_pkg::ST_DIFF_MUL: begin
            mul_a = $signed(diff_sat);
            mul_b = $signed(gain_ff);
         end
         asmf_pkg::ST_V2_MUL: begin
            mul_a = $signed({{(VW - asmf_pkg::RAW_W){1'b0}}, raw2_ff});
            mul_b = $signed({{(VW - asmf_pkg::VOLT_W){1'b0}}, vref_ff});
         end
         asmf_pkg::ST_RES_MUL: begin
            mul_a = spike_ff ? mid : avg;
            mul_b = $signed(gain_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= asmf_pkg::ST_IDLE;
         for (int i = 0; i < asmf_pkg::CHANNELS; i++) begin
            store_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (state_ff == asmf_pkg::ST_RES_ENG && eng_value != '1) begin
            store_ff[idx] <= eng_value;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (accept) begin
         ch_ff   <= req_channel;
         raw1_ff <= req_first_raw;
         raw2_ff <= req_second_raw;
         cur_ff  <= req_channel_is_current;
         if (!in_range) begin
            result_ff <= '0;
            spike_ff  <= 1'b0;
            keep_ff   <= 1'b0;
         end
      end
      unique case (state_ff)
         asmf_pkg::ST_V1_MUL: begin
            num_ff <= $signed({store_ff[idx][VW-1], store_ff[idx]})
                      - $signed({offset_ff[VW-1], offset_ff});
         end
         asmf_pkg::ST_V1_CLAMP: begin
            v1_ff <= asmf_pkg::clamp_volts(product[VW-1:asmf_pkg::RAW_W], min_ff, max_ff);
         end
         asmf_pkg::ST_BACK:     back_ff  <= back_in;
         asmf_pkg::ST_DIFF:     diff_ff  <= diff_in;
         asmf_pkg::ST_DIFF_ENG: spike_ff <= spike_in;
         asmf_pkg::ST_V2_CLAMP: begin
            v2_ff <= asmf_pkg::clamp_volts(product[VW-1:asmf_pkg::RAW_W], min_ff, max_ff);
         end
         asmf_pkg::ST_RES_ENG: begin
            result_ff <= eng_value;
            keep_ff   <= eng_value != '1;
         end
         default: begin
         end
      endcase
   end

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_ch_ff        <= ch_ff;
         rsp_value_ff     <= result_ff;
         rsp_resampled_ff <= spike_ff;
         rsp_stored_ff    <= keep_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_channel    = rsp_ch_ff;
   assign rsp_filtered_value = rsp_value_ff;
   assign rsp_resampled      = rsp_resampled_ff;
   assign rsp_stored         = rsp_stored_ff;

endmodule

// ----- hw/rtl/asmf_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asmf_checker
// Port-level assertions for the analog spike median filter core.
// ----------------------------------------------------------------------------
module asmf_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic [asmf_pkg::CH_W-1:0]           req_channel,
   input logic [asmf_pkg::RAW_W-1:0]          req_first_raw,
   input logic [asmf_pkg::RAW_W-1:0]          req_second_raw,
   input logic                                req_channel_is_current,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [asmf_pkg::CH_W-1:0]           rsp_out_channel,
   input logic signed [asmf_pkg::VAL_W-1:0]   rsp_filtered_value,
   input logic                                rsp_resampled,
   input logic                                rsp_stored,
   input logic                                csr_write,
   input logic [asmf_pkg::CSR_IDX_W-1:0]      csr_index,
   input logic [asmf_pkg::VAL_W-1:0]          csr_data
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_filtered_value)
                                 && $stable(rsp_out_channel) && $stable(rsp_stored))
      else $error("stalled result changed");

   // one request at a time: busy right after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while busy");

   // all-ones pattern is never reported as stored
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stored |-> rsp_filtered_value != '1)
      else $error("all-ones value marked stored");

   // out-of-range channel gives an empty result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ({3'b000, rsp_out_channel} >= asmf_pkg::CH_CMP_W'(asmf_pkg::CHANNELS))
      |-> rsp_filtered_value == '0 && !rsp_stored && !rsp_resampled)
      else $error("out-of-range channel produced data");

endmodule

bind analog_spike_median_filter_core asmf_checker u_asmf_checker (.*);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for analog_spike_median_filter_core. A scoreboard class
// carries its own copy of the channel store and settings and works out the
// filtered value, the resample flag and the store flag for every accepted
// request. Results are compared field by field in order. Directed requests
// at the field extremes and special settings come first. Randomized phases
// with fresh settings, sender bursts and receiver stalls follow.
// ----------------------------------------------------------------------------
module tb_top;

   typedef struct {
      logic [asmf_pkg::CH_W-1:0]         channel;
      logic signed [asmf_pkg::VAL_W-1:0] value;
      logic                              resampled;
      logic                              stored;
   } filter_result_type;

   typedef enum {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_TOGGLE} stall_mode_type;

   class filter_scoreboard;
      longint vref, lo_clamp, hi_clamp, gain, offset, temp_thr, humi_thr, dc_thr;
      longint chan_value[asmf_pkg::CHANNELS];
      filter_result_type expected_results[$];
      int errors;

      function new();
         vref     = 327680;
         lo_clamp = 0;
         hi_clamp = 786432;
         gain     = 65536;
         offset   = 0;
         temp_thr = 65536;
         humi_thr = 65536;
         dc_thr   = 65536;
         foreach (chan_value[i]) chan_value[i] = 0;
         errors = 0;
      endfunction

      function void report(string what);
         $display("MISMATCH @%0t: %s", $time, what);
         errors++;
      endfunction

      function void set_register(asmf_pkg::cfg_index_type idx,
                                 logic [asmf_pkg::VAL_W-1:0] data);
         case (idx)
            asmf_pkg::CFG_VREF:   vref     = longint'(data[asmf_pkg::VOLT_W-1:0]);
            asmf_pkg::CFG_MIN:    lo_clamp = longint'(data[asmf_pkg::VOLT_W-1:0]);
            asmf_pkg::CFG_MAX:    hi_clamp = longint'(data[asmf_pkg::VOLT_W-1:0]);
            asmf_pkg::CFG_GAIN:   gain     = longint'($signed(data));
            asmf_pkg::CFG_OFFSET: offset   = longint'($signed(data));
            asmf_pkg::CFG_TEMP:   temp_thr = longint'(data[asmf_pkg::THR_W-1:0]);
            asmf_pkg::CFG_HUMI:   humi_thr = longint'(data[asmf_pkg::THR_W-1:0]);
            asmf_pkg::CFG_DC:     dc_thr   = longint'(data[asmf_pkg::VOLT_W-1:0]);
            default: ;
         endcase
      endfunction

      function longint saturate(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      // upper clamp is tested first, so with crossed limits only values above the upper one get it
      function longint raw_volts(logic [asmf_pkg::RAW_W-1:0] raw);
         longint v;
         v = (longint'(raw) * vref) >> 12;
         if (v > hi_clamp) v = hi_clamp;
         else if (v < lo_clamp) v = lo_clamp;
         return v;
      endfunction

      function longint eng_units(longint v);
         return saturate(v * gain / 65536 + offset);
      endfunction

      function void note_request(logic [asmf_pkg::CH_W-1:0] ch,
                                 logic [asmf_pkg::RAW_W-1:0] r1,
                                 logic [asmf_pkg::RAW_W-1:0] r2, logic cur);
         filter_result_type e;
         longint v1, v2, back, num, diff, thr, hi, lo, mid, res;
         logic spike;
         e.channel = ch;
         if (int'(ch) >= asmf_pkg::CHANNELS) begin
            e.value = '0;
            e.resampled = 1'b0;
            e.stored = 1'b0;
            expected_results.push_back(e);
            return;
         end
         v1 = raw_volts(r1);
         num = chan_value[ch] - offset;
         if (gain == 0) begin
            back = (num >= 0) ? 64'sd2147483647 : -64'sd2147483648;
         end else begin
            back = saturate(num * 65536 / gain);
         end
         diff = (v1 > back) ? v1 - back : back - v1;
         if (ch == 0 || ch == 1) begin
            thr = (ch == 0) ? temp_thr : humi_thr;
            spike = eng_units(saturate(diff)) > thr;
         end else begin
            thr = cur ? dc_thr / 240 : dc_thr;
            spike = diff > thr;
         end
         if (spike) begin
            hi = (v1 > back) ? v1 : back;
            lo = (v1 > back) ? back : v1;
            v2 = raw_volts(r2);
            if (hi <= v2) mid = hi;
            else if (v2 <= lo) mid = lo;
            else mid = v2;
            res = eng_units(mid);
         end else begin
            res = eng_units((back + v1) / 2);
         end
         e.value = res[asmf_pkg::VAL_W-1:0];
         e.resampled = spike;
         e.stored = (res[asmf_pkg::VAL_W-1:0] != 32'hFFFF_FFFF);
         if (e.stored) chan_value[ch] = res;
         expected_results.push_back(e);
      endfunction

      function void check_result(logic [asmf_pkg::CH_W-1:0] ch,
                                 logic signed [asmf_pkg::VAL_W-1:0] value,
                                 logic resampled, logic stored);
         filter_result_type e;
         if (expected_results.size() == 0) begin
            report($sformatf("unexpected result ch=%0d value=%0d", ch, value));
            return;
         end
         e = expected_results.pop_front();
         if (ch !== e.channel)
            report($sformatf("channel %0d, want %0d", ch, e.channel));
         if (value !== e.value)
            report($sformatf("ch %0d value %0d, want %0d", e.channel, value, e.value));
         if (resampled !== e.resampled)
            report($sformatf("ch %0d resampled %b, want %b", e.channel, resampled,
                             e.resampled));
         if (stored !== e.stored)
            report($sformatf("ch %0d stored %b, want %b", e.channel, stored, e.stored));
      endfunction

      function int pending();
         return expected_results.size();
      endfunction
   endclass

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic [asmf_pkg::CH_W-1:0]         req_channel = '0;
   logic [asmf_pkg::RAW_W-1:0]        req_first_raw = '0;
   logic [asmf_pkg::RAW_W-1:0]        req_second_raw = '0;
   logic                              req_channel_is_current = 1'b0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic [asmf_pkg::CH_W-1:0]         rsp_out_channel;
   logic signed [asmf_pkg::VAL_W-1:0] rsp_filtered_value;
   logic                              rsp_resampled;
   logic                              rsp_stored;
   logic                              csr_write = 1'b0;
   logic [asmf_pkg::CSR_IDX_W-1:0]    csr_index = '0;
   logic [asmf_pkg::VAL_W-1:0]        csr_data = '0;

   filter_scoreboard sb = new();
   int rsp_hold_cycles = 0;
   logic [asmf_pkg::RAW_W-1:0] recent_raw [asmf_pkg::CHANNELS];

   analog_spike_median_filter_core uut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_channel            (req_channel),
      .req_first_raw          (req_first_raw),
      .req_second_raw         (req_second_raw),
      .req_channel_is_current (req_channel_is_current),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_out_channel        (rsp_out_channel),
      .rsp_filtered_value     (rsp_filtered_value),
      .rsp_resampled          (rsp_resampled),
      .rsp_stored             (rsp_stored),
      .csr_write              (csr_write),
      .csr_index              (csr_index),
      .csr_data               (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         sb.note_request(req_channel, req_first_raw, req_second_raw,
                         req_channel_is_current);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_out_channel, rsp_filtered_value, rsp_resampled, rsp_stored);
   end

   // receiver: stall pattern of its own, plus a long hold on demand
   initial begin
      stall_mode_type mode;
      int span;
      mode = STALL_NONE;
      span = 0;
      forever begin
         @(posedge clock);
         if (span == 0) begin
            mode = stall_mode_type'($urandom_range(0, 3));
            span = $urandom_range(20, 400);
         end
         span--;
         if (rsp_hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            rsp_hold_cycles--;
         end else begin
            case (mode)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_HALF:  rsp_stall <= 1'($urandom_range(0, 1));
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) != 0);
               default:     rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   // valid stays high after return; caller lowers it when a gap follows
   task automatic send_request(input logic [asmf_pkg::CH_W-1:0] ch,
                               input logic [asmf_pkg::RAW_W-1:0] r1,
                               input logic [asmf_pkg::RAW_W-1:0] r2, input logic cur);
      req_valid <= 1'b1;
      req_channel <= ch;
      req_first_raw <= r1;
      req_second_raw <= r2;
      req_channel_is_current <= cur;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
   endtask

   // wait for the clock first so the last accepted request is already on the scoreboard
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input asmf_pkg::cfg_index_type idx,
                            input logic [asmf_pkg::VAL_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      sb.set_register(idx, data);
      @(posedge clock);
   endtask

   task automatic program_settings(input logic [asmf_pkg::VAL_W-1:0] vr,
                                   input logic [asmf_pkg::VAL_W-1:0] mn,
                                   input logic [asmf_pkg::VAL_W-1:0] mx,
                                   input logic [asmf_pkg::VAL_W-1:0] gk,
                                   input logic [asmf_pkg::VAL_W-1:0] ob,
                                   input logic [asmf_pkg::VAL_W-1:0] tt,
                                   input logic [asmf_pkg::VAL_W-1:0] ht,
                                   input logic [asmf_pkg::VAL_W-1:0] dt);
      write_csr(asmf_pkg::CFG_VREF, vr);
      write_csr(asmf_pkg::CFG_MIN, mn);
      write_csr(asmf_pkg::CFG_MAX, mx);
      write_csr(asmf_pkg::CFG_GAIN, gk);
      write_csr(asmf_pkg::CFG_OFFSET, ob);
      write_csr(asmf_pkg::CFG_TEMP, tt);
      write_csr(asmf_pkg::CFG_HUMI, ht);
      write_csr(asmf_pkg::CFG_DC, dt);
      csr_write <= 1'b0;
   endtask

   task automatic random_settings();
      logic [asmf_pkg::VAL_W-1:0] vr, mn, mx, gk, ob, tt, ht, dt;
      case ($urandom_range(0, 5))
         0:       vr = 32'd1048575;
         1:       vr = 32'd0;
         default: vr = $urandom_range(65536, 524288);
      endcase
      case ($urandom_range(0, 5))
         0: begin
            mn = 32'd0;
            mx = 32'd1048575;
         end
         1: begin
            mn = $urandom_range(300000, 1048575);
            mx = $urandom_range(0, 300000);
         end
         default: begin
            mn = $urandom_range(0, 100000);
            mx = $urandom_range(mn, 1048575);
         end
      endcase
      case ($urandom_range(0, 7))
         0:       gk = 32'd0;
         1:       gk = 32'h7FFF_FFFF;
         2:       gk = 32'h8000_0000;
         3:       gk = 32'd1;
         default: begin
            gk = $urandom_range(1, 1 << 20);
            if ($urandom_range(0, 1)) gk = -gk;
         end
      endcase
      case ($urandom_range(0, 6))
         0:       ob = 32'd0;
         1:       ob = 32'hFFFF_FFFF;
         2:       ob = 32'h7FFF_FFFF;
         3:       ob = 32'h8000_0000;
         default: begin
            ob = $urandom_range(0, 1 << 22);
            if ($urandom_range(0, 1)) ob = -ob;
         end
      endcase
      case ($urandom_range(0, 4))
         0:       tt = 32'd0;
         1:       tt = 32'h7FFF_FFFF;
         default: tt = $urandom_range(0, 1 << 20);
      endcase
      case ($urandom_range(0, 4))
         0:       ht = 32'd0;
         1:       ht = 32'h7FFF_FFFF;
         default: ht = $urandom_range(0, 1 << 20);
      endcase
      case ($urandom_range(0, 4))
         0:       dt = 32'd0;
         1:       dt = 32'd1048575;
         default: dt = $urandom_range(0, 200000);
      endcase
      program_settings(vr, mn, mx, gk, ob, tt, ht, dt);
   endtask

   function automatic logic [asmf_pkg::RAW_W-1:0] near_raw(
      input logic [asmf_pkg::RAW_W-1:0] base);
      int t;
      t = int'(base) + $urandom_range(0, 16) - 8;
      if (t < 0) t = 0;
      if (t > 4095) t = 4095;
      return t[asmf_pkg::RAW_W-1:0];
   endfunction

   function automatic logic [asmf_pkg::RAW_W-1:0] pick_raw(
      input logic [asmf_pkg::RAW_W-1:0] base);
      case ($urandom_range(0, 9))
         0:       return 12'd0;
         1:       return 12'd4095;
         2, 3, 4, 5: return near_raw(base);
         default: return asmf_pkg::RAW_W'($urandom_range(0, 4095));
      endcase
   endfunction

   // readings often track the previous one on the channel so both the
   // averaging and the median paths stay busy
   task automatic send_random_item();
      logic [asmf_pkg::CH_W-1:0] ch;
      logic [asmf_pkg::RAW_W-1:0] r1, r2;
      if ($urandom_range(0, 9) < 3) ch = asmf_pkg::CH_W'($urandom_range(0, 1));
      else ch = asmf_pkg::CH_W'($urandom_range(0, 15));
      r1 = pick_raw(recent_raw[ch]);
      r2 = pick_raw(r1);
      recent_raw[ch] = r1;
      send_request(ch, r1, r2, 1'($urandom_range(0, 1)));
   endtask

   initial begin
      int burst_left, gap;
      foreach (recent_raw[i]) recent_raw[i] = asmf_pkg::RAW_W'($urandom_range(0, 4095));
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: 5 V reference, unity gain, 1.0 thresholds
      send_request(4'd0, 12'd0, 12'd0, 1'b0);
      send_request(4'd0, 12'd4095, 12'd4095, 1'b0);
      send_request(4'd0, 12'd4095, 12'd0, 1'b0);
      send_request(4'd0, 12'd0, 12'd2048, 1'b0);
      send_request(4'd1, 12'd2048, 12'd0, 1'b0);
      send_request(4'd1, 12'd2100, 12'd2100, 1'b1);
      send_request(4'd2, 12'd4095, 12'd1000, 1'b0);
      send_request(4'd3, 12'd100, 12'd4095, 1'b1);
      send_request(4'd3, 12'd101, 12'd0, 1'b1);
      send_request(4'd15, 12'd4095, 12'd4095, 1'b1);
      send_request(4'd15, 12'd0, 12'd0, 1'b0);
      send_request(4'd2, 12'd4095, 12'd4095, 1'b0);
      settle();

      // zero gain with offset -1: every result is all ones and never stored
      program_settings(32'd327680, 32'd0, 32'd786432, 32'd0, 32'hFFFF_FFFF,
                       32'd65536, 32'd65536, 32'd65536);
      send_request(4'd0, 12'd4095, 12'd0, 1'b0);
      send_request(4'd5, 12'd0, 12'd4095, 1'b1);
      send_request(4'd1, 12'd123, 12'd3000, 1'b0);
      settle();

      // crossed clamps, full-scale reference, negative gain
      program_settings(32'd1048575, 32'd800000, 32'd100000, 32'hFFFF_0000, 32'h7FFF_FFFF,
                       32'd0, 32'h7FFF_FFFF, 32'd0);
      send_request(4'd0, 12'd4095, 12'd0, 1'b0);
      send_request(4'd1, 12'd0, 12'd4095, 1'b0);
      send_request(4'd4, 12'd2048, 12'd2048, 1'b1);
      send_request(4'd4, 12'd1, 12'd4095, 1'b0);
      settle();

      // extreme gain and offset, zero reference
      program_settings(32'd0, 32'd0, 32'd1048575, 32'h7FFF_FFFF, 32'h8000_0000,
                       32'h7FFF_FFFF, 32'd0, 32'd1048575);
      send_request(4'd0, 12'd4095, 12'd4095, 1'b0);
      send_request(4'd1, 12'd0, 12'd0, 1'b1);
      send_request(4'd6, 12'd4095, 12'd0, 1'b1);
      send_request(4'd6, 12'd0, 12'd4095, 1'b0);
      settle();

      for (int phase = 0; phase < 12; phase++) begin
         random_settings();
         burst_left = 0;
         for (int n = 0; n < 170; n++) begin
            if (burst_left == 0) begin
               gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
               if (gap > 0) begin
                  req_valid <= 1'b0;
                  repeat (gap) @(posedge clock);
               end
               burst_left = $urandom_range(1, 24);
            end
            // long receiver hold while requests keep coming
            if (phase == 4 && n == 10) rsp_hold_cycles = 500;
            send_random_item();
            burst_left--;
         end
         settle();
      end

      repeat (100) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("** analog_spike_median_filter_core: PASSED **");
      end else begin
         $display("** analog_spike_median_filter_core: FAILED **");
      end
      $finish;
   end

   initial begin
      #15000000;
      $display("timeout with %0d results outstanding", sb.pending());
      $display("** analog_spike_median_filter_core: FAILED **");
      $finish;
   end

endmodule
